FILE: src/sotc_pkg.sv
// ----------------------------------------------------------------------------
// sotc_pkg
// Shared types and constants of the octagonal stick and trigger clamp.
// ----------------------------------------------------------------------------
package sotc_pkg;

    localparam int STICK_LAT = 12;
    localparam int DIV_STAGES = 8;

    localparam logic [2:0] REG_TRIGGER_FLOOR   = 3'd0;
    localparam logic [2:0] REG_TRIGGER_CEILING = 3'd1;
    localparam logic [2:0] REG_MAIN_DEADZONE   = 3'd2;
    localparam logic [2:0] REG_MAIN_RADIUS     = 3'd3;
    localparam logic [2:0] REG_MAIN_DIAGONAL   = 3'd4;
    localparam logic [2:0] REG_SUB_DEADZONE    = 3'd5;
    localparam logic [2:0] REG_SUB_RADIUS      = 3'd6;
    localparam logic [2:0] REG_SUB_DIAGONAL    = 3'd7;

    localparam logic [7:0] RST_TRIGGER_FLOOR   = 8'd30;
    localparam logic [7:0] RST_TRIGGER_CEILING = 8'd180;
    localparam logic [6:0] RST_MAIN_DEADZONE   = 7'd15;
    localparam logic [6:0] RST_MAIN_RADIUS     = 7'd72;
    localparam logic [6:0] RST_MAIN_DIAGONAL   = 7'd40;
    localparam logic [6:0] RST_SUB_DEADZONE    = 7'd15;
    localparam logic [6:0] RST_SUB_RADIUS      = 7'd59;
    localparam logic [6:0] RST_SUB_DIAGONAL    = 7'd31;

    typedef struct packed {
        logic [6:0] deadzone;
        logic [6:0] radius;
        logic [6:0] diagonal;
    } stick_cfg_t;

    typedef struct packed {
        logic        conn;
        logic        neg_x;
        logic        neg_y;
        logic        scale;
        logic [7:0]  mag_x;
        logic [7:0]  mag_y;
        logic [7:0]  raw_x;
        logic [7:0]  raw_y;
    } stick_side_t;

    typedef struct packed {
        logic        conn;
        logic        neg_x;
        logic        neg_y;
        logic [7:0]  mag_x;
        logic [7:0]  mag_y;
        logic [7:0]  raw_x;
        logic [7:0]  raw_y;
    } stick_s1_t;

    typedef struct packed {
        stick_s1_t           s1;
        logic [14:0]         major_prod;
        logic signed [16:0]  minor_prod;
        logic [13:0]         lim;
    } stick_s2_t;

endpackage

FILE: src/stick_octagon_trigger_clamp_top.sv
// ----------------------------------------------------------------------------
// stick_octagon_trigger_clamp_top
// Octagonal dead-zone clamp of two sticks and dead-zone clamp of two triggers.
// ----------------------------------------------------------------------------
// A word is accepted in every cycle in which start is high; busy is always
// low. Each result word appears on the clamped outputs, marked by done, for one
// cycle, after three stages of dead zone and octagon arithmetic, eight stages of
// the bit-per-stage divider and one output register. The receiver cannot stall,
// and none is needed.
module stick_octagon_trigger_clamp_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              connected,
    input  logic signed [7:0] main_x,
    input  logic signed [7:0] main_y,
    input  logic signed [7:0] sub_x,
    input  logic signed [7:0] sub_y,
    input  logic [7:0]        left_trigger,
    input  logic [7:0]        right_trigger,
    output logic              done,
    output logic signed [7:0] clamped_main_x,
    output logic signed [7:0] clamped_main_y,
    output logic signed [7:0] clamped_sub_x,
    output logic signed [7:0] clamped_sub_y,
    output logic [7:0]        clamped_left_trigger,
    output logic [7:0]        clamped_right_trigger,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [7:0]        cfg_data
);
    import sotc_pkg::*;

    logic [7:0]  floor_reg, ceil_reg;
    stick_cfg_t  main_cfg_reg, sub_cfg_reg;
    logic [STICK_LAT-1:0] vld_reg;
    logic [15:0] trg_reg [STICK_LAT];
    logic [15:0] trg_next;

    function automatic logic [7:0] trig(input logic [7:0] t, input logic [7:0] fl,
                                        input logic [7:0] cl);
        logic [7:0] c;
        if (t <= fl)
            return 8'd0;
        c = (cl < t) ? cl : t;
        return (c > fl) ? c - fl : 8'd0;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_reg <= RST_TRIGGER_FLOOR;
            ceil_reg <= RST_TRIGGER_CEILING;
            main_cfg_reg <= '{RST_MAIN_DEADZONE, RST_MAIN_RADIUS, RST_MAIN_DIAGONAL};
            sub_cfg_reg <= '{RST_SUB_DEADZONE, RST_SUB_RADIUS, RST_SUB_DIAGONAL};
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[STICK_LAT-2:0], start};
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TRIGGER_FLOOR:   floor_reg <= cfg_data;
                    REG_TRIGGER_CEILING: ceil_reg <= cfg_data;
                    REG_MAIN_DEADZONE:   main_cfg_reg.deadzone <= cfg_data[6:0];
                    REG_MAIN_RADIUS:     main_cfg_reg.radius <= cfg_data[6:0];
                    REG_MAIN_DIAGONAL:   main_cfg_reg.diagonal <= cfg_data[6:0];
                    REG_SUB_DEADZONE:    sub_cfg_reg.deadzone <= cfg_data[6:0];
                    REG_SUB_RADIUS:      sub_cfg_reg.radius <= cfg_data[6:0];
                    REG_SUB_DIAGONAL:    sub_cfg_reg.diagonal <= cfg_data[6:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb
    begin
        if (connected)
            trg_next = {trig(left_trigger, floor_reg, ceil_reg),
                        trig(right_trigger, floor_reg, ceil_reg)};
        else
            trg_next = {left_trigger, right_trigger};
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < STICK_LAT; k++)
            trg_reg[k] <= (k == 0) ? trg_next : trg_reg[(k == 0) ? 0 : k - 1];
    end

    sotc_stick u_main (
        .clk(clk), .cfg(main_cfg_reg), .conn(connected),
        .raw_x(main_x), .raw_y(main_y),
        .out_x(clamped_main_x), .out_y(clamped_main_y)
    );

    sotc_stick u_sub (
        .clk(clk), .cfg(sub_cfg_reg), .conn(connected),
        .raw_x(sub_x), .raw_y(sub_y),
        .out_x(clamped_sub_x), .out_y(clamped_sub_y)
    );

    assign busy = 1'b0;
    assign done = vld_reg[STICK_LAT-1];
    assign clamped_left_trigger  = trg_reg[STICK_LAT-1][15:8];
    assign clamped_right_trigger = trg_reg[STICK_LAT-1][7:0];

endmodule

FILE: src/sotc_div.sv
// ----------------------------------------------------------------------------
// sotc_div
// Pipelined restoring divider, one quotient bit per stage. The quotient is
// known to be below 256.
// ----------------------------------------------------------------------------
module sotc_div (
    input  logic        clk,
    input  logic [20:0] num,
    input  logic [15:0] den,
    output logic [7:0]  quo
);
    import sotc_pkg::*;

    logic [20:0] rem_reg  [DIV_STAGES];
    logic [15:0] den_reg  [DIV_STAGES];
    logic [7:0]  quo_reg  [DIV_STAGES];
    logic [20:0] rem_next [DIV_STAGES];
    logic [7:0]  quo_next [DIV_STAGES];

    always_comb
    begin
        logic [20:0] r_in;
        logic [15:0] d_in;
        logic [7:0]  q_in;
        logic [22:0] sub;
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            r_in = (k == 0) ? num : rem_reg[(k == 0) ? 0 : k - 1];
            d_in = (k == 0) ? den : den_reg[(k == 0) ? 0 : k - 1];
            q_in = (k == 0) ? 8'd0 : quo_reg[(k == 0) ? 0 : k - 1];
            sub = {7'd0, d_in} << (DIV_STAGES - 1 - k);
            rem_next[k] = r_in;
            quo_next[k] = q_in;
            if ({2'd0, r_in} >= sub)
            begin
                rem_next[k] = r_in - sub[20:0];
                quo_next[k][DIV_STAGES - 1 - k] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            rem_reg[k] <= rem_next[k];
            quo_reg[k] <= quo_next[k];
            den_reg[k] <= (k == 0) ? den : den_reg[(k == 0) ? 0 : k - 1];
        end
    end

    assign quo = quo_reg[DIV_STAGES - 1];

endmodule

FILE: src/sotc_stick.sv
// ----------------------------------------------------------------------------
// sotc_stick
// Dead zone and octagon clamp of one stick, twelve register stages.
// ----------------------------------------------------------------------------
module sotc_stick (
    input  logic                 clk,
    input  sotc_pkg::stick_cfg_t cfg,
    input  logic                 conn,
    input  logic signed [7:0]    raw_x,
    input  logic signed [7:0]    raw_y,
    output logic signed [7:0]    out_x,
    output logic signed [7:0]    out_y
);
    import sotc_pkg::*;

    stick_s1_t   s1_reg, s1_next;
    stick_s2_t   s2_reg, s2_next;
    stick_side_t s3_reg, s3_next;
    stick_side_t side_reg [DIV_STAGES];
    logic [20:0] num_x_reg, num_y_reg;
    logic [20:0] num_x_next, num_y_next;
    logic [15:0] den_reg, den_next;
    logic [7:0]  q_x, q_y;
    logic [7:0]  out_x_reg, out_y_reg;
    logic [7:0]  out_x_next, out_y_next;

    function automatic logic [7:0] dz_mag(input logic [7:0] v, input logic [6:0] dz);
        logic [7:0] m;
        m = v[7] ? (~v + 8'd1) : v;
        return (m <= {1'b0, dz}) ? 8'd0 : m - {1'b0, dz};
    endfunction

    function automatic logic [7:0] restore(input logic [7:0] m, input logic neg);
        if (neg)
            return ~m + 8'd1;
        return (m > 8'd127) ? 8'd127 : m;
    endfunction

    always_comb
    begin
        s1_next.conn  = conn;
        s1_next.neg_x = raw_x[7];
        s1_next.neg_y = raw_y[7];
        s1_next.mag_x = dz_mag(raw_x, cfg.deadzone);
        s1_next.mag_y = dz_mag(raw_y, cfg.deadzone);
        s1_next.raw_x = raw_x;
        s1_next.raw_y = raw_y;
    end

    always_comb
    begin
        logic             sel;
        logic [7:0]       major, minor;
        logic signed [7:0] rd;
        sel = (cfg.diagonal == 7'd0) || (s1_reg.mag_y <= s1_reg.mag_x);
        major = sel ? s1_reg.mag_x : s1_reg.mag_y;
        minor = sel ? s1_reg.mag_y : s1_reg.mag_x;
        rd = $signed({1'b0, cfg.radius}) - $signed({1'b0, cfg.diagonal});
        s2_next.s1 = s1_reg;
        s2_next.major_prod = cfg.diagonal * major;
        s2_next.minor_prod = $signed({1'b0, minor}) * rd;
        s2_next.lim = cfg.diagonal * cfg.radius;
    end

    always_comb
    begin
        logic signed [17:0] d;
        d = $signed({3'd0, s2_reg.major_prod}) + 18'(s2_reg.minor_prod);
        s3_next.conn  = s2_reg.s1.conn;
        s3_next.neg_x = s2_reg.s1.neg_x;
        s3_next.neg_y = s2_reg.s1.neg_y;
        s3_next.scale = $signed({4'd0, s2_reg.lim}) < d;
        s3_next.mag_x = s2_reg.s1.mag_x;
        s3_next.mag_y = s2_reg.s1.mag_y;
        s3_next.raw_x = s2_reg.s1.raw_x;
        s3_next.raw_y = s2_reg.s1.raw_y;
        den_next   = d[15:0];
        num_x_next = 21'(s2_reg.lim) * 21'(s2_reg.s1.mag_x);
        num_y_next = 21'(s2_reg.lim) * 21'(s2_reg.s1.mag_y);
    end

    sotc_div u_div_x (.clk(clk), .num(num_x_reg), .den(den_reg), .quo(q_x));
    sotc_div u_div_y (.clk(clk), .num(num_y_reg), .den(den_reg), .quo(q_y));

    always_comb
    begin
        stick_side_t s;
        s = side_reg[DIV_STAGES - 1];
        if (!s.conn)
        begin
            out_x_next = s.raw_x;
            out_y_next = s.raw_y;
        end
        else
        begin
            out_x_next = restore(s.scale ? q_x : s.mag_x, s.neg_x);
            out_y_next = restore(s.scale ? q_y : s.mag_y, s.neg_y);
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
        s2_reg <= s2_next;
        s3_reg <= s3_next;
        num_x_reg <= num_x_next;
        num_y_reg <= num_y_next;
        den_reg <= den_next;
        for (int k = 0; k < DIV_STAGES; k++)
            side_reg[k] <= (k == 0) ? s3_reg : side_reg[(k == 0) ? 0 : k - 1];
        out_x_reg <= out_x_next;
        out_y_reg <= out_y_next;
    end

    assign out_x = out_x_reg;
    assign out_y = out_y_reg;

endmodule
